// ----- rtl/sro_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Sequence reorder buffer package
// Window geometry, field widths, status codes and payload width helpers.
// ----------------------------------------------------------------------------
package sro_pkg;

    localparam int WINDOW_DEPTH  = 32;
    localparam int PAYLOAD_WIDTH = 32;
    localparam int SEQ_W         = 16;
    localparam int IN_PAY_W      = 32;
    localparam int OUT_PAY_W     = 32;
    localparam int SLOT_W        = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

    typedef logic [SEQ_W-1:0]         seq_t;
    typedef logic [SLOT_W-1:0]        slot_t;
    typedef logic [PAYLOAD_WIDTH-1:0] payload_t;
    typedef logic [1:0]               status_t;

    localparam status_t ST_RELEASED  = 2'd0;
    localparam status_t ST_HELD      = 2'd1;
    localparam status_t ST_OUTSIDE   = 2'd2;
    localparam status_t ST_DUPLICATE = 2'd3;

    function automatic payload_t pay_from_in(input logic [IN_PAY_W-1:0] value);
        logic [PAYLOAD_WIDTH+IN_PAY_W-1:0] wide;
        wide = {{PAYLOAD_WIDTH{1'b0}}, value};
        return wide[PAYLOAD_WIDTH-1:0];
    endfunction

    function automatic logic [OUT_PAY_W-1:0] pay_to_out(input payload_t value);
        logic [PAYLOAD_WIDTH+OUT_PAY_W-1:0] wide;
        wide = {{OUT_PAY_W{1'b0}}, value};
        return wide[OUT_PAY_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ----- rtl/sro_in_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Sequence reorder buffer input channel
// Valid/ready channel that carries one tagged work item.
// ----------------------------------------------------------------------------
interface sro_in_if;
    import sro_pkg::*;

    logic                valid;
    logic                ready;
    logic [SEQ_W-1:0]    sequence_number;
    logic [IN_PAY_W-1:0] item_payload;

    modport source (output valid, output sequence_number, output item_payload, input ready);
    modport sink   (input valid, input sequence_number, input item_payload, output ready);
endinterface
`default_nettype wire

// ----- rtl/sro_out_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Sequence reorder buffer result channel
// Valid/ready channel that carries one release or status item.
// ----------------------------------------------------------------------------
interface sro_out_if;
    import sro_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [1:0]           status;
    logic [SEQ_W-1:0]     released_sequence;
    logic [OUT_PAY_W-1:0] released_payload;
    logic                 last_of_run;

    modport source (output valid, output status, output released_sequence,
                    output released_payload, output last_of_run, input ready);
    modport sink   (input valid, input status, input released_sequence,
                    input released_payload, input last_of_run, output ready);
endinterface
`default_nettype wire

// ----- rtl/sequence_reorder_buffer_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Sequence reorder buffer unit
// An item that is rejected or held yields its status item in the cycle after
// acceptance. An item that closes a gap is first stored, then the payload
// memory is read, then the unit releases one item per cycle while the
// result side takes them; the single read port of the payload memory sets
// that pace. After reset all slots are empty and item 1 is expected; no
// clearing pass is needed.
// ----------------------------------------------------------------------------
module sequence_reorder_buffer_unit (
    input  wire logic clk,
    input  wire logic rst_n,
    sro_in_if.sink    item_ch,
    sro_out_if.source result_ch
);
    import sro_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_READ, S_LOAD} state_t;

    localparam logic [SLOT_W:0] DEPTH_WIDE = (SLOT_W+1)'(WINDOW_DEPTH);
    localparam slot_t           SLOT_LAST  = SLOT_W'(WINDOW_DEPTH - 1);
    localparam slot_t           SLOT_ONE   = SLOT_W'(1);
    localparam seq_t            SEQ_MAX    = {SEQ_W{1'b1}};

    state_t                  state_reg, state_next;
    seq_t                    exp_reg, exp_next;
    slot_t                   exp_slot_reg, exp_slot_next;
    logic [WINDOW_DEPTH-1:0] valid_reg, valid_next;
    logic                    out_valid_reg, out_valid_next;
    status_t                 out_status_reg, out_status_next;
    seq_t                    out_seq_reg, out_seq_next;
    logic [OUT_PAY_W-1:0]    out_pay_reg, out_pay_next;
    logic                    out_last_reg, out_last_next;

    logic            out_free;
    logic            accept;
    seq_t            offset;
    logic            in_window;
    logic [SLOT_W:0] slot_sum;
    logic [SLOT_W:0] slot_red;
    slot_t           in_slot;
    slot_t           next_slot;
    logic            more;
    logic            ram_we;
    logic            ram_re;
    slot_t           ram_raddr;
    payload_t        ram_rdata;
    payload_t        in_pay;

    sro_ram #(
        .WIDTH (PAYLOAD_WIDTH),
        .DEPTH (WINDOW_DEPTH)
    ) u_payload_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (in_slot),
        .wdata (in_pay),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_free      = !out_valid_reg || result_ch.ready;
    assign item_ch.ready = (state_reg == S_IDLE) && out_free;
    assign accept        = item_ch.valid && item_ch.ready;
    assign in_pay        = pay_from_in(item_ch.item_payload);

    // The slot follows from the expected slot plus the offset; a tag that
    // wrapped past the top of the sequence space is below the depth itself.
    assign offset    = item_ch.sequence_number - exp_reg;
    assign in_window = offset < SEQ_W'(WINDOW_DEPTH);
    assign slot_sum  = {1'b0, exp_slot_reg} + {1'b0, offset[SLOT_W-1:0]};
    assign slot_red  = (slot_sum >= DEPTH_WIDE) ? (slot_sum - DEPTH_WIDE) : slot_sum;
    assign in_slot   = (item_ch.sequence_number < exp_reg)
                       ? item_ch.sequence_number[SLOT_W-1:0] : slot_red[SLOT_W-1:0];

    assign next_slot = ((exp_reg == SEQ_MAX) || (exp_slot_reg == SLOT_LAST))
                       ? '0 : exp_slot_reg + SLOT_ONE;
    assign more      = valid_reg[next_slot];

    always_comb
    begin
        state_next      = state_reg;
        exp_next        = exp_reg;
        exp_slot_next   = exp_slot_reg;
        valid_next      = valid_reg;
        out_valid_next  = out_valid_reg && !result_ch.ready;
        out_status_next = out_status_reg;
        out_seq_next    = out_seq_reg;
        out_pay_next    = out_pay_reg;
        out_last_next   = out_last_reg;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        ram_raddr       = exp_slot_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    out_seq_next  = item_ch.sequence_number;
                    out_pay_next  = pay_to_out(in_pay);
                    out_last_next = 1'b1;
                    if (!in_window)
                    begin
                        out_valid_next  = 1'b1;
                        out_status_next = ST_OUTSIDE;
                    end
                    else if (valid_reg[in_slot])
                    begin
                        out_valid_next  = 1'b1;
                        out_status_next = ST_DUPLICATE;
                    end
                    else
                    begin
                        ram_we              = 1'b1;
                        valid_next[in_slot] = 1'b1;
                        if (item_ch.sequence_number == exp_reg)
                        begin
                            state_next = S_READ;
                        end
                        else
                        begin
                            out_valid_next  = 1'b1;
                            out_status_next = ST_HELD;
                        end
                    end
                end
            end
            S_READ:
            begin
                ram_re     = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (out_free)
                begin
                    out_valid_next             = 1'b1;
                    out_status_next            = ST_RELEASED;
                    out_seq_next               = exp_reg;
                    out_pay_next               = pay_to_out(ram_rdata);
                    out_last_next              = !more;
                    valid_next[exp_slot_reg]   = 1'b0;
                    exp_next                   = exp_reg + SEQ_W'(1);
                    exp_slot_next              = next_slot;
                    if (more)
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = next_slot;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            exp_reg        <= SEQ_W'(1);
            exp_slot_reg   <= SLOT_ONE;
            valid_reg      <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= ST_RELEASED;
            out_seq_reg    <= '0;
            out_pay_reg    <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            exp_reg        <= exp_next;
            exp_slot_reg   <= exp_slot_next;
            valid_reg      <= valid_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_seq_reg    <= out_seq_next;
            out_pay_reg    <= out_pay_next;
            out_last_reg   <= out_last_next;
        end
    end

    assign result_ch.valid             = out_valid_reg;
    assign result_ch.status            = out_status_reg;
    assign result_ch.released_sequence = out_seq_reg;
    assign result_ch.released_payload  = out_pay_reg;
    assign result_ch.last_of_run       = out_last_reg;

endmodule
`default_nettype wire

// ----- rtl/sro_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read that holds its
// data while no read is requested.
// ----------------------------------------------------------------------------
module sro_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic                                   re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire
